// ===== sv/fvs_pkg.sv =====
// Package for the formation velocity steering block.
// Holds stage counts, register codes, reset values and the sideband record.
// Used by every module of the block; depends on nothing.
package fvs_pkg;

    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = 24;
    localparam int NUM_W       = 56;
    localparam int DEN_W       = 32;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_EASE_DISTANCE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSE_RATIO   = 8'd1;

    localparam logic [30:0] EASE_RESET  = 31'd400;
    localparam logic [15:0] CLOSE_RESET = 16'd7864;

    typedef struct packed {
        logic               dx_neg;
        logic               dy_neg;
        logic [31:0]        ax;
        logic [31:0]        ay;
        logic [22:0]        max_speed;
        logic signed [23:0] dest_vx;
        logic signed [23:0] dest_vy;
        logic signed [23:0] ship_vx;
        logic signed [23:0] ship_vy;
        logic [62:0]        dist_sq;
        logic [31:0]        dist_len;
        logic signed [23:0] tx;
        logic signed [23:0] ty;
        logic               near;
        logic               sx_neg;
        logic               sy_neg;
        logic signed [24:0] dv_x;
        logic signed [24:0] dv_y;
    } side_t;

    typedef struct packed {
        logic en;
        logic valid;
    } pipe_ctl_t;

endpackage

// ===== sv/fvs_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Carries the sideband record alongside; uses fvs_pkg.
module fvs_isqrt
    import fvs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  pipe_ctl_t   in_ctl,
    input  logic [63:0] radicand,
    input  side_t       in_side,
    output logic        out_valid,
    output logic [31:0] root,
    output side_t       out_side
);

    logic [63:0] rem_reg   [SQRT_STAGES];
    logic [63:0] root_reg  [SQRT_STAGES];
    side_t       side_reg  [SQRT_STAGES];
    logic        valid_reg [SQRT_STAGES];

    genvar k;
    generate
        for (k = 0; k < SQRT_STAGES; k++) begin : g_stage
            localparam logic [63:0] BIT_W = 64'd1 << (2 * (SQRT_STAGES - 1 - k));
            logic [63:0] rem_in;
            logic [63:0] root_in;
            side_t       side_in;
            logic        valid_in;
            logic [63:0] trial;
            logic        take;
            logic [63:0] rem_next;
            logic [63:0] root_next;

            if (k == 0) begin : g_first
                assign rem_in   = radicand;
                assign root_in  = 64'd0;
                assign side_in  = in_side;
                assign valid_in = in_ctl.valid;
            end else begin : g_rest
                assign rem_in   = rem_reg[k-1];
                assign root_in  = root_reg[k-1];
                assign side_in  = side_reg[k-1];
                assign valid_in = valid_reg[k-1];
            end

            assign trial     = root_in + BIT_W;
            assign take      = rem_in >= trial;
            assign rem_next  = take ? rem_in - trial : rem_in;
            assign root_next = take ? (root_in >> 1) + BIT_W : root_in >> 1;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else if (in_ctl.en)
                begin
                    valid_reg[k] <= valid_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (in_ctl.en)
                begin
                    rem_reg[k]  <= rem_next;
                    root_reg[k] <= root_next;
                    side_reg[k] <= side_in;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[SQRT_STAGES-1];
    assign root      = root_reg[SQRT_STAGES-1][31:0];
    assign out_side  = side_reg[SQRT_STAGES-1];

endmodule

// ===== sv/fvs_div.sv =====
// Pipelined two-lane restoring divider with a shared divisor, one quotient
// bit per stage. Carries the sideband record; uses fvs_pkg.
module fvs_div
    import fvs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  pipe_ctl_t             in_ctl,
    input  logic [NUM_W-1:0]      num_x,
    input  logic [NUM_W-1:0]      num_y,
    input  logic [DEN_W-1:0]      den,
    input  side_t                 in_side,
    output logic                  out_valid,
    output logic [DIV_STAGES-1:0] quo_x,
    output logic [DIV_STAGES-1:0] quo_y,
    output side_t                 out_side
);

    logic [NUM_W-1:0]      rx_reg    [DIV_STAGES];
    logic [NUM_W-1:0]      ry_reg    [DIV_STAGES];
    logic [DIV_STAGES-1:0] qx_reg    [DIV_STAGES];
    logic [DIV_STAGES-1:0] qy_reg    [DIV_STAGES];
    logic [DEN_W-1:0]      den_reg   [DIV_STAGES];
    side_t                 side_reg  [DIV_STAGES];
    logic                  valid_reg [DIV_STAGES];

    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++) begin : g_stage
            localparam int BIT_POS = DIV_STAGES - 1 - k;
            logic [NUM_W-1:0]      rx_in;
            logic [NUM_W-1:0]      ry_in;
            logic [DIV_STAGES-1:0] qx_in;
            logic [DIV_STAGES-1:0] qy_in;
            logic [DEN_W-1:0]      den_in;
            side_t                 side_in;
            logic                  valid_in;
            logic [NUM_W-1:0]      trial;
            logic                  take_x;
            logic                  take_y;
            logic [NUM_W-1:0]      rx_next;
            logic [NUM_W-1:0]      ry_next;
            logic [DIV_STAGES-1:0] qx_next;
            logic [DIV_STAGES-1:0] qy_next;

            if (k == 0) begin : g_first
                assign rx_in    = num_x;
                assign ry_in    = num_y;
                assign qx_in    = '0;
                assign qy_in    = '0;
                assign den_in   = den;
                assign side_in  = in_side;
                assign valid_in = in_ctl.valid;
            end else begin : g_rest
                assign rx_in    = rx_reg[k-1];
                assign ry_in    = ry_reg[k-1];
                assign qx_in    = qx_reg[k-1];
                assign qy_in    = qy_reg[k-1];
                assign den_in   = den_reg[k-1];
                assign side_in  = side_reg[k-1];
                assign valid_in = valid_reg[k-1];
            end

            assign trial  = NUM_W'(den_in) << BIT_POS;
            assign take_x = rx_in >= trial;
            assign take_y = ry_in >= trial;

            always_comb
            begin
                rx_next = take_x ? rx_in - trial : rx_in;
                ry_next = take_y ? ry_in - trial : ry_in;
                qx_next = qx_in;
                qy_next = qy_in;
                qx_next[BIT_POS] = take_x;
                qy_next[BIT_POS] = take_y;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else if (in_ctl.en)
                begin
                    valid_reg[k] <= valid_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (in_ctl.en)
                begin
                    rx_reg[k]   <= rx_next;
                    ry_reg[k]   <= ry_next;
                    qx_reg[k]   <= qx_next;
                    qy_reg[k]   <= qy_next;
                    den_reg[k]  <= den_in;
                    side_reg[k] <= side_in;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign quo_x     = qx_reg[DIV_STAGES-1];
    assign quo_y     = qy_reg[DIV_STAGES-1];
    assign out_side  = side_reg[DIV_STAGES-1];

endmodule

// ===== sv/formation_velocity_steering_top.sv =====
// Top level of the formation velocity steering block.
// Front end, blend and output stages; uses fvs_pkg, fvs_isqrt and fvs_div.
//
//   channel  direction  handshake               payload
//   in       input      in_valid / in_ready     dest, ship position and velocity, max_speed
//   out      output     out_valid / out_ready   dv_x, dv_y, dist_sq, dv_sq, close_enough
//   cfg      input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One beat enters per cycle while the output is not held; the pipeline is the 32 square root
// stages and the two 24 stage dividers plus 13 arithmetic stages.
// Reset clears all valid bits and loads the register reset values.
// A held output beat stalls the whole pipeline together, so nothing is lost
// or repeated; cfg_ready is always high.
module formation_velocity_steering_top
    import fvs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [30:0]    dest_x,
    input  logic signed [30:0]    dest_y,
    input  logic signed [23:0]    dest_vx,
    input  logic signed [23:0]    dest_vy,
    input  logic signed [30:0]    ship_x,
    input  logic signed [30:0]    ship_y,
    input  logic signed [23:0]    ship_vx,
    input  logic signed [23:0]    ship_vy,
    input  logic [22:0]           max_speed,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [24:0]    dv_x,
    output logic signed [24:0]    dv_y,
    output logic [62:0]           dist_sq,
    output logic [49:0]           dv_sq,
    output logic                  close_enough,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic        en;
    logic [30:0] ease_reg;
    logic [15:0] close_reg;

    logic               s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic               s5_valid_reg, s6_valid_reg, s7_valid_reg, s8_valid_reg;
    logic               s9_valid_reg, s10_valid_reg, s11_valid_reg, s12_valid_reg;
    logic               out_valid_reg;
    side_t              s1_side_reg, s2_side_reg, s3_side_reg, s4_side_reg, s5_side_reg;
    side_t              s6_side_reg, s7_side_reg, s8_side_reg, s9_side_reg;
    side_t              s10_side_reg, s11_side_reg, s12_side_reg;
    logic signed [31:0] dx_reg, dy_reg;
    logic [63:0]        sqx_reg, sqy_reg, d2_reg;
    logic [54:0]        nx_reg, ny_reg;
    logic signed [56:0] px_reg, py_reg, ex_reg, ey_reg;
    logic signed [57:0] sumx_reg, sumy_reg;
    logic [NUM_W-1:0]   magx_reg, magy_reg;
    logic [49:0]        dsqx_reg, dsqy_reg, dvsq_reg;
    logic [22:0]        c_reg;
    logic [45:0]        c2_reg;
    logic signed [24:0] dv_x_reg, dv_y_reg;
    logic [62:0]        dist_sq_reg;
    logic [49:0]        dv_sq_reg;
    logic               close_reg_out;

    side_t              s1_side_next, s2_side_next, s4_side_next, s5_side_next;
    side_t              s6_side_next, s9_side_next, s10_side_next;
    logic signed [31:0] dx_next, dy_next;
    logic [63:0]        d2_next;
    logic [31:0]        ediff;
    logic signed [56:0] px_next, py_next, ex_next, ey_next;
    logic signed [57:0] negx, negy;
    logic signed [24:0] wx, wy;
    logic signed [49:0] dsqx_next, dsqy_next;
    logic [38:0]        cprod;

    pipe_ctl_t          sq_ctl, d1_ctl, d2_ctl;
    logic               sq_valid, d1_valid, d2_valid;
    logic [31:0]        root;
    side_t              sq_side, d1_side, d2_side;
    logic [DIV_STAGES-1:0] q1x, q1y, q2x, q2y;

    assign en        = !out_valid_reg || out_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ease_reg  <= EASE_RESET;
            close_reg <= CLOSE_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_EASE_DISTANCE: ease_reg  <= cfg_data[30:0];
                REG_CLOSE_RATIO:   close_reg <= cfg_data[15:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        dx_next = {dest_x[30], dest_x} - {ship_x[30], ship_x};
        dy_next = {dest_y[30], dest_y} - {ship_y[30], ship_y};
        s1_side_next           = '0;
        s1_side_next.max_speed = max_speed;
        s1_side_next.dest_vx   = dest_vx;
        s1_side_next.dest_vy   = dest_vy;
        s1_side_next.ship_vx   = ship_vx;
        s1_side_next.ship_vy   = ship_vy;

        s2_side_next        = s1_side_reg;
        s2_side_next.dx_neg = dx_reg[31];
        s2_side_next.dy_neg = dy_reg[31];
        s2_side_next.ax     = dx_reg[31] ? 32'(-dx_reg) : dx_reg;
        s2_side_next.ay     = dy_reg[31] ? 32'(-dy_reg) : dy_reg;

        d2_next              = sqx_reg + sqy_reg;
        s4_side_next         = s3_side_reg;
        s4_side_next.dist_sq = d2_next[63] ? '1 : d2_next[62:0];

        s5_side_next          = sq_side;
        s5_side_next.dist_len = root;

        s6_side_next      = d1_side;
        s6_side_next.tx   = (d1_side.dist_len == 32'd0) ? 24'sd0 :
                            (d1_side.dx_neg ? 24'(-q1x) : q1x);
        s6_side_next.ty   = (d1_side.dist_len == 32'd0) ? 24'sd0 :
                            (d1_side.dy_neg ? 24'(-q1y) : q1y);
        s6_side_next.near = d1_side.dist_len < {1'b0, ease_reg};

        ediff   = {1'b0, ease_reg} - s6_side_reg.dist_len;
        px_next = $signed({1'b0, s6_side_reg.dist_len}) * s6_side_reg.tx;
        py_next = $signed({1'b0, s6_side_reg.dist_len}) * s6_side_reg.ty;
        ex_next = $signed({1'b0, ediff}) * s6_side_reg.dest_vx;
        ey_next = $signed({1'b0, ediff}) * s6_side_reg.dest_vy;

        negx                = -sumx_reg;
        negy                = -sumy_reg;
        s9_side_next        = s8_side_reg;
        s9_side_next.sx_neg = sumx_reg[57];
        s9_side_next.sy_neg = sumy_reg[57];

        wx = d2_side.near ? (d2_side.sx_neg ? 25'(-{1'b0, q2x}) : {1'b0, q2x}) :
                            {d2_side.tx[23], d2_side.tx};
        wy = d2_side.near ? (d2_side.sy_neg ? 25'(-{1'b0, q2y}) : {1'b0, q2y}) :
                            {d2_side.ty[23], d2_side.ty};
        s10_side_next      = d2_side;
        s10_side_next.dv_x = wx - {d2_side.ship_vx[23], d2_side.ship_vx};
        s10_side_next.dv_y = wy - {d2_side.ship_vy[23], d2_side.ship_vy};

        dsqx_next = s10_side_reg.dv_x * s10_side_reg.dv_x;
        dsqy_next = s10_side_reg.dv_y * s10_side_reg.dv_y;
        cprod     = close_reg * s10_side_reg.max_speed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            s7_valid_reg  <= 1'b0;
            s8_valid_reg  <= 1'b0;
            s9_valid_reg  <= 1'b0;
            s10_valid_reg <= 1'b0;
            s11_valid_reg <= 1'b0;
            s12_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= sq_valid;
            s6_valid_reg  <= d1_valid;
            s7_valid_reg  <= s6_valid_reg;
            s8_valid_reg  <= s7_valid_reg;
            s9_valid_reg  <= s8_valid_reg;
            s10_valid_reg <= d2_valid;
            s11_valid_reg <= s10_valid_reg;
            s12_valid_reg <= s11_valid_reg;
            out_valid_reg <= s12_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg        <= dx_next;
            dy_reg        <= dy_next;
            s1_side_reg   <= s1_side_next;
            s2_side_reg   <= s2_side_next;
            sqx_reg       <= s2_side_reg.ax * s2_side_reg.ax;
            sqy_reg       <= s2_side_reg.ay * s2_side_reg.ay;
            s3_side_reg   <= s2_side_reg;
            d2_reg        <= d2_next;
            s4_side_reg   <= s4_side_next;
            nx_reg        <= sq_side.ax * sq_side.max_speed;
            ny_reg        <= sq_side.ay * sq_side.max_speed;
            s5_side_reg   <= s5_side_next;
            s6_side_reg   <= s6_side_next;
            px_reg        <= px_next;
            py_reg        <= py_next;
            ex_reg        <= ex_next;
            ey_reg        <= ey_next;
            s7_side_reg   <= s6_side_reg;
            sumx_reg      <= px_reg + ex_reg;
            sumy_reg      <= py_reg + ey_reg;
            s8_side_reg   <= s7_side_reg;
            magx_reg      <= sumx_reg[57] ? negx[NUM_W-1:0] : sumx_reg[NUM_W-1:0];
            magy_reg      <= sumy_reg[57] ? negy[NUM_W-1:0] : sumy_reg[NUM_W-1:0];
            s9_side_reg   <= s9_side_next;
            s10_side_reg  <= s10_side_next;
            dsqx_reg      <= dsqx_next;
            dsqy_reg      <= dsqy_next;
            c_reg         <= cprod[38:16];
            s11_side_reg  <= s10_side_reg;
            dvsq_reg      <= dsqx_reg + dsqy_reg;
            c2_reg        <= c_reg * c_reg;
            s12_side_reg  <= s11_side_reg;
            dv_x_reg      <= s12_side_reg.dv_x;
            dv_y_reg      <= s12_side_reg.dv_y;
            dist_sq_reg   <= s12_side_reg.dist_sq;
            dv_sq_reg     <= dvsq_reg;
            close_reg_out <= dvsq_reg < {4'd0, c2_reg};
        end
    end

    assign sq_ctl = '{en: en, valid: s4_valid_reg};
    assign d1_ctl = '{en: en, valid: s5_valid_reg};
    assign d2_ctl = '{en: en, valid: s9_valid_reg};

    fvs_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ctl   (sq_ctl),
        .radicand (d2_reg),
        .in_side  (s4_side_reg),
        .out_valid(sq_valid),
        .root     (root),
        .out_side (sq_side)
    );

    fvs_div u_div_travel (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ctl   (d1_ctl),
        .num_x    ({1'b0, nx_reg}),
        .num_y    ({1'b0, ny_reg}),
        .den      (s5_side_reg.dist_len),
        .in_side  (s5_side_reg),
        .out_valid(d1_valid),
        .quo_x    (q1x),
        .quo_y    (q1y),
        .out_side (d1_side)
    );

    fvs_div u_div_blend (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ctl   (d2_ctl),
        .num_x    (magx_reg),
        .num_y    (magy_reg),
        .den      ({1'b0, ease_reg}),
        .in_side  (s9_side_reg),
        .out_valid(d2_valid),
        .quo_x    (q2x),
        .quo_y    (q2y),
        .out_side (d2_side)
    );

    assign out_valid    = out_valid_reg;
    assign dv_x         = dv_x_reg;
    assign dv_y         = dv_y_reg;
    assign dist_sq      = dist_sq_reg;
    assign dv_sq        = dv_sq_reg;
    assign close_enough = close_reg_out;

endmodule

// ===== tb/sv/fvs_checker.sv =====
// Checker for the formation velocity steering block: watches the input,
// output and register channels, predicts every result and compares it.
// Depends on fvs_pkg for the register codes and reset values.
module fvs_checker
    import fvs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic signed [30:0]    dest_x,
    input  logic signed [30:0]    dest_y,
    input  logic signed [23:0]    dest_vx,
    input  logic signed [23:0]    dest_vy,
    input  logic signed [30:0]    ship_x,
    input  logic signed [30:0]    ship_y,
    input  logic signed [23:0]    ship_vx,
    input  logic signed [23:0]    ship_vy,
    input  logic [22:0]           max_speed,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic signed [24:0]    dv_x,
    input  logic signed [24:0]    dv_y,
    input  logic [62:0]           dist_sq,
    input  logic [49:0]           dv_sq,
    input  logic                  close_enough,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [24:0] dv_x;
        logic signed [24:0] dv_y;
        logic [62:0]        dist_sq;
        logic [49:0]        dv_sq;
        logic               close_enough;
    } steer_t;

    steer_t      steer_queue[$];
    logic [30:0] ease_reg;
    logic [15:0] close_reg;

    assign outstanding = steer_queue.size();

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic steer_t steer_predict();
        steer_t          s;
        longint          dx, dy, dlen, ms, tx, ty, wx, wy, e, dvx, dvy;
        longint unsigned ax, ay, d2, dsq2, c;
        dx = longint'(dest_x) - longint'(ship_x);
        dy = longint'(dest_y) - longint'(ship_y);
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        d2 = ax * ax + ay * ay;
        dlen = longint'(int_sqrt(d2));
        ms = longint'({41'd0, max_speed});
        tx = 0;
        ty = 0;
        if (dlen != 0)
        begin
            tx = (dx * ms) / dlen;
            ty = (dy * ms) / dlen;
        end
        wx = tx;
        wy = ty;
        e = longint'({33'd0, ease_reg});
        if (dlen < e)
        begin
            wx = (dlen * tx + (e - dlen) * longint'(dest_vx)) / e;
            wy = (dlen * ty + (e - dlen) * longint'(dest_vy)) / e;
        end
        dvx = wx - longint'(ship_vx);
        dvy = wy - longint'(ship_vy);
        ax = (dvx < 0) ? -dvx : dvx;
        ay = (dvy < 0) ? -dvy : dvy;
        dsq2 = ax * ax + ay * ay;
        c = ({48'd0, close_reg} * {41'd0, max_speed}) >> 16;
        s.dv_x = dvx[24:0];
        s.dv_y = dvy[24:0];
        s.dist_sq = (d2 > 64'h7fff_ffff_ffff_ffff) ? 63'h7fff_ffff_ffff_ffff : d2[62:0];
        s.dv_sq = dsq2[49:0];
        s.close_enough = (dsq2 < c * c);
        return s;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        steer_t want;
        int     errs;
        errs = 0;
        if (!rst_n)
        begin
            ease_reg <= EASE_RESET;
            close_reg <= CLOSE_RESET;
            fail_count <= 0;
            steer_queue.delete();
        end
        else
        begin
            if (in_valid && in_ready)
                steer_queue.push_back(steer_predict());
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_EASE_DISTANCE)
                    ease_reg <= cfg_data[30:0];
                else if (cfg_index == REG_CLOSE_RATIO)
                    close_reg <= cfg_data[15:0];
            end
            if (out_valid && out_ready)
            begin
                if (steer_queue.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    errs++;
                end
                else
                begin
                    want = steer_queue.pop_front();
                    if (dv_x !== want.dv_x)
                    begin
                        $error("dv_x expected %0d got %0d", want.dv_x, dv_x);
                        errs++;
                    end
                    if (dv_y !== want.dv_y)
                    begin
                        $error("dv_y expected %0d got %0d", want.dv_y, dv_y);
                        errs++;
                    end
                    if (dist_sq !== want.dist_sq)
                    begin
                        $error("dist_sq expected %0d got %0d", want.dist_sq, dist_sq);
                        errs++;
                    end
                    if (dv_sq !== want.dv_sq)
                    begin
                        $error("dv_sq expected %0d got %0d", want.dv_sq, dv_sq);
                        errs++;
                    end
                    if (close_enough !== want.close_enough)
                    begin
                        $error("close_enough expected %0b got %0b",
                               want.close_enough, close_enough);
                        errs++;
                    end
                end
            end
            if (errs != 0)
                fail_count <= fail_count + errs;
        end
    end
endmodule

// ===== tb/sv/testbench.sv =====
// Top of the formation velocity steering testbench: clock, reset, stimulus
// with bursts and receiver stalls, register phases and the verdict.
// Depends on fvs_pkg, formation_velocity_steering_top and fvs_checker.
module testbench;
    import fvs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 140;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [30:0] dest_x = '0, dest_y = '0, ship_x = '0, ship_y = '0;
    logic signed [23:0] dest_vx = '0, dest_vy = '0, ship_vx = '0, ship_vy = '0;
    logic [22:0] max_speed = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [24:0] dv_x, dv_y;
    logic [62:0] dist_sq;
    logic [49:0] dv_sq;
    logic close_enough;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int fail_count;
    int outstanding;
    int cycles = 0;
    int burst_left = 0;
    int stall_mode = 0;

    always #5 clk = ~clk;

    formation_velocity_steering_top uut (.*);

    fvs_checker chk (.*);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cycles % 300 == 0)
                stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 1) == 1);
                2: out_ready <= ($urandom_range(0, 7) == 0);
                default: out_ready <= ((cycles % 16) < 11);
            endcase
        end
    end

    task automatic send_beat(input logic signed [30:0] tx_x, input logic signed [30:0] tx_y,
                             input logic signed [23:0] tvx, input logic signed [23:0] tvy,
                             input logic signed [30:0] sx, input logic signed [30:0] sy,
                             input logic signed [23:0] svx, input logic signed [23:0] svy,
                             input logic [22:0] ms);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 30);
        end
        burst_left--;
        in_valid <= 1'b1;
        dest_x <= tx_x;
        dest_y <= tx_y;
        dest_vx <= tvx;
        dest_vy <= tvy;
        ship_x <= sx;
        ship_y <= sy;
        ship_vx <= svx;
        ship_vy <= svy;
        max_speed <= ms;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic drain_all();
        in_valid <= 1'b0;
        burst_left = 0;
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_beat();
        logic signed [30:0] sx, sy, tx_x, tx_y;
        logic signed [23:0] v0, v1, v2, v3;
        logic [22:0] ms;
        int k;
        sx = 31'($urandom());
        sy = 31'($urandom());
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                tx_x = 31'($urandom());
                tx_y = 31'($urandom());
            end
            3:
            begin
                tx_x = sx;
                tx_y = sy;
            end
            default:
            begin
                sx = {{3{sx[30]}}, sx[27:0]};
                sy = {{3{sy[30]}}, sy[27:0]};
                k = $urandom_range(0, 27);
                tx_x = 31'(sx + ($signed($urandom()) >>> (31 - k)));
                tx_y = 31'(sy + ($signed($urandom()) >>> (31 - k)));
            end
        endcase
        v0 = 24'($urandom());
        v1 = 24'($urandom());
        v2 = 24'($urandom());
        v3 = 24'($urandom());
        ms = 23'($urandom());
        if ($urandom_range(0, 2) == 0)
        begin
            v0 = v0 >>> 12;
            v1 = v1 >>> 12;
            v2 = v2 >>> 12;
            v3 = v3 >>> 12;
            ms = ms >> 12;
        end
        send_beat(tx_x, tx_y, v0, v1, sx, sy, v2, v3, ms);
    endtask

    initial
    begin
        logic signed [30:0] pmax, pmin;
        logic signed [23:0] vmax, vmin;
        pmax = 31'h3fff_ffff;
        pmin = 31'h4000_0000;
        vmax = 24'h7f_ffff;
        vmin = 24'h80_0000;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_beat(5, 5, vmax, vmin, 5, 5, vmin, vmax, 23'h7f_ffff);
        send_beat(pmax, pmax, vmax, vmax, pmin, pmin, vmin, vmin, 23'h7f_ffff);
        send_beat(pmin, pmin, vmin, vmin, pmax, pmax, vmax, vmax, 23'h7f_ffff);
        send_beat(pmax, pmin, vmax, vmin, pmin, pmax, vmax, vmin, 0);
        send_beat(300, 0, 100, -100, 0, 0, 0, 0, 1000);
        send_beat(0, -399, vmin, vmax, 0, 0, vmax, vmin, 23'h7f_ffff);
        send_beat(400, 0, 10, 10, 0, 0, 0, 0, 500);
        send_beat(401, 0, 10, 10, 0, 0, 0, 0, 500);
        send_beat(1, 0, 0, 0, 0, 0, 0, 0, 1);
        send_beat(1000, 1000, 0, 0, 0, 0, 700, 700, 1000);
        send_beat(1000, 1000, 0, 0, 0, 0, 706, 706, 1000);
        send_beat(-3, 4, -2, 2, 0, 0, 1, -1, 7);
        send_beat(pmax, 0, 0, 0, pmin, 0, 0, 0, 23'h7f_ffff);
        drain_all();

        for (int phase = 0; phase < 7; phase++)
        begin
            drain_all();
            case (phase)
                1:
                begin
                    write_reg(REG_EASE_DISTANCE, 32'd1);
                    write_reg(REG_CLOSE_RATIO, 32'd0);
                end
                2:
                begin
                    write_reg(REG_EASE_DISTANCE, 32'h7fff_ffff);
                    write_reg(REG_CLOSE_RATIO, 32'h0000_ffff);
                end
                3:
                begin
                    write_reg(REG_EASE_DISTANCE, 32'h8000_0000);
                    write_reg(REG_CLOSE_RATIO, 32'hffff_8000);
                end
                4:
                begin
                    write_reg(REG_UNUSED, 32'd12345);
                    write_reg(REG_EASE_DISTANCE, 32'd5000);
                    write_reg(REG_CLOSE_RATIO, 32'd13107);
                end
                5:
                begin
                    write_reg(REG_EASE_DISTANCE, 32'd1000000);
                    write_reg(REG_CLOSE_RATIO, 32'd65535);
                end
                6:
                begin
                    write_reg(REG_EASE_DISTANCE, 32'd400);
                    write_reg(REG_CLOSE_RATIO, 32'd7864);
                end
                default: ;
            endcase
            repeat (170)
                random_beat();
        end

        drain_all();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// ===== formation_velocity_steering_top.f =====
sv/fvs_pkg.sv
sv/fvs_isqrt.sv
sv/fvs_div.sv
sv/formation_velocity_steering_top.sv
tb/sv/fvs_checker.sv
tb/sv/testbench.sv
